@@ rtl/core/ssps_pkg.sv @@
`default_nettype none
package ssps_pkg;

    typedef enum logic [1:0] {
        KIND_SKY   = 2'd0,
        KIND_GREEN = 2'd1,
        KIND_BLUE  = 2'd2,
        KIND_MOVE  = 2'd3
    } t_kind;

    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;

    localparam int COORD_W = 16;
    localparam int HARG_W  = 23;
    localparam int NZ_W    = 12;

    localparam int ORIGIN_X_OFS = 7282;
    localparam int ORIGIN_Y_OFS = 4096;
    localparam int FIXED_CX     = 2048;
    localparam int RSQ_Q24      = 1 << 22;
    localparam int TENTH_Q12    = 410;
    localparam int ONE_Q12      = 4096;

    localparam int DIV_STEPS  = 13;
    localparam int BYTE_SCALE = 255999;
    localparam int BYTE_REC   = 33554;
    localparam int BYTE_DIV   = 125;

    localparam logic [7:0] SKY_R = 8'd191;
    localparam logic [7:0] SKY_G = 8'd217;
    localparam logic [7:0] SKY_B = 8'd255;
    localparam logic [7:0] FULL  = 8'd255;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef struct packed {
        t_kind                     kind;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic [HARG_W-1:0]         harg;
    } t_item;

    typedef struct packed {
        t_kind                     kind;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
    } t_geo;

    typedef struct packed {
        t_geo            geo;
        logic [NZ_W-1:0] nz;
    } t_lsb;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage
`default_nettype wire

@@ rtl/core/sphere_scene_pixel_shader_top.sv @@
// port          dir  width        meaning
// start/busy    in   11+10        pixel word, taken when start is high and busy low
// i_cfg_*       in   2 idx, 16    movable sphere centre write, taken when i_cfg_we is high
// o_valid       out  8+8+8+2      color word, present for exactly one cycle
//
// one pixel per clock while busy is low; the path holds the two
// square-root pipelines (12 and 16 stages) and the 13-stage normal divider
// reset is synchronous, active low; it clears all valid flags and the centre registers
// busy rises only if the front queue fills; the back end drains it every cycle
// results cannot be held off by the receiver
`default_nettype none
module sphere_scene_pixel_shader_top #(
    parameter int PIX_COLS = 1600,
    parameter int PIX_ROWS = 900
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [10:0] i_pixel_col,
    input  wire logic [9:0]  i_pixel_row,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_valid,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [1:0]       o_hit_kind
);

    logic signed [15:0] r_center_x, r_center_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ssps_pkg::CFG_CENTER_X: r_center_x <= i_cfg_data;
                ssps_pkg::CFG_CENTER_Y: r_center_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ssps_pkg::t_qstat w_qstat;
    ssps_pkg::t_item  w_push_item, w_pop_item;
    ssps_pkg::t_kind  w_kind;
    logic             w_accept, w_push, w_pop_v;

    assign busy     = w_qstat.full;
    assign w_accept = start && !busy;

    ssps_front #(
        .PIX_COLS (PIX_COLS),
        .PIX_ROWS (PIX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_pixel_col (i_pixel_col),
        .i_pixel_row (i_pixel_row),
        .i_center_x  (r_center_x),
        .i_center_y  (r_center_y),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    ssps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_valid (w_pop_v),
        .o_item  (w_pop_item),
        .o_qstat (w_qstat)
    );

    ssps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pop_v),
        .i_item  (w_pop_item),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue),
        .o_kind  (w_kind)
    );

    assign o_hit_kind = w_kind;

    // back end never lets the queue fill
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("front queue filled");

    // normal z is never negative, so blue stays in the upper half
    a_move_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_hit_kind == ssps_pkg::KIND_MOVE)) |-> (o_blue >= 8'd127))
        else $error("movable sphere blue channel below midpoint");

    // no word leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result word after reset");

endmodule
`default_nettype wire

@@ rtl/core/ssps_isqrt.sv @@
`default_nettype none
module ssps_isqrt #(
    parameter int IN_W  = 32,
    parameter int SB_W  = 1,
    parameter int OUT_W = (IN_W + 1) / 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [IN_W-1:0]  i_rad,
    input  wire logic [SB_W-1:0]  i_sb,
    output logic                  o_valid,
    output logic [OUT_W-1:0]      o_root,
    output logic [SB_W-1:0]       o_sb
);

    localparam int TW = IN_W + 2;

    logic [IN_W-1:0]  r_rem  [OUT_W-1];
    logic [OUT_W-1:0] r_root [OUT_W];
    logic [SB_W-1:0]  r_sb   [OUT_W];
    logic             r_v    [OUT_W];

    // one result bit per stage, msb first
    for (genvar gs = 0; gs < OUT_W; gs++) begin : g_stage
        localparam int B = OUT_W - 1 - gs;
        logic [IN_W-1:0]  w_rem;
        logic [OUT_W-1:0] w_root;
        logic [SB_W-1:0]  w_sb;
        logic             w_v;
        logic [TW-1:0]    w_trial;
        logic             w_take;

        if (gs == 0) begin : g_first
            assign w_rem  = i_rad;
            assign w_root = '0;
            assign w_sb   = i_sb;
            assign w_v    = i_valid;
        end else begin : g_next
            assign w_rem  = r_rem[gs-1];
            assign w_root = r_root[gs-1];
            assign w_sb   = r_sb[gs-1];
            assign w_v    = r_v[gs-1];
        end

        assign w_trial = (TW'(w_root) << (B + 1)) | (TW'(1) << (2 * B));
        assign w_take  = TW'(w_rem) >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gs] <= 1'b0;
            end else begin
                r_v[gs] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_root[gs] <= w_take ? (w_root | (OUT_W'(1) << B)) : w_root;
            r_sb[gs]   <= w_sb;
        end

        if (gs < OUT_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[gs] <= w_take ? (w_rem - w_trial[IN_W-1:0]) : w_rem;
            end
        end
    end

    assign o_valid = r_v[OUT_W-1];
    assign o_root  = r_root[OUT_W-1];
    assign o_sb    = r_sb[OUT_W-1];

endmodule
`default_nettype wire

@@ rtl/core/ssps_front.sv @@
`default_nettype none
module ssps_front #(
    parameter int PIX_COLS = 1600,
    parameter int PIX_ROWS = 900
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [10:0]          i_pixel_col,
    input  wire logic [9:0]           i_pixel_row,
    input  wire logic signed [15:0]   i_center_x,
    input  wire logic signed [15:0]   i_center_y,
    input  wire ssps_pkg::t_qstat     i_qstat,
    output logic                      o_push,
    output ssps_pkg::t_item           o_item
);

    localparam int  DEN_X   = 9 * (PIX_COLS - 1);
    localparam int  DEN_Y   = PIX_ROWS - 1;
    localparam int  NX_W    = 29;
    localparam int  NY_W    = 24;
    localparam int  REC_SH  = 30;
    localparam longint REC_X = (64'sd1 <<< REC_SH) / DEN_X;
    localparam longint REC_Y = (64'sd1 <<< REC_SH) / DEN_Y;
    localparam int  REC_X_W = $clog2(REC_X + 1);
    localparam int  REC_Y_W = $clog2(REC_Y + 1);
    localparam int  PX_W    = NX_W + REC_X_W;
    localparam int  PY_W    = NY_W + REC_Y_W;
    localparam int  VX_W    = NX_W + 2;
    localparam int  VY_W    = NY_W + 2;
    localparam int  SQ_W    = 34;
    localparam int  SUM_W   = 35;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] res;
        priority if (v > 32'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    logic w_adv;
    assign w_adv = !i_qstat.full;

    // stage 0: input word
    logic        r_v0;
    logic [10:0] r_col0;
    logic [9:0]  r_row0;
    logic [NX_W-1:0] w_nx;
    logic [NY_W-1:0] w_ny;
    assign w_nx = (NX_W'(r_col0) << 17) + NX_W'(DEN_X / 2);
    assign w_ny = (NY_W'(r_row0) << 13) + NY_W'(DEN_Y / 2);

    // stage 1: reciprocal products
    logic            r_v1;
    logic [NX_W-1:0] r_nx1;
    logic [NY_W-1:0] r_ny1;
    logic [PX_W-1:0] r_px1;
    logic [PY_W-1:0] r_py1;
    logic [NX_W-1:0] w_qex;
    logic [NY_W-1:0] w_qey;
    assign w_qex = NX_W'(r_px1 >> REC_SH);
    assign w_qey = NY_W'(r_py1 >> REC_SH);

    // stage 2: back products
    logic            r_v2;
    logic [NX_W-1:0] r_nx2, r_qex2, r_prx2;
    logic [NY_W-1:0] r_ny2, r_qey2, r_pry2;

    // stage 3: corrected quotients
    logic            r_v3;
    logic [NX_W-1:0] r_qx3;
    logic [NY_W-1:0] r_qy3;
    logic signed [VX_W-1:0] w_vx;
    logic signed [VY_W-1:0] w_vy;
    assign w_vx = $signed({2'b00, r_qx3}) - VX_W'(ssps_pkg::ORIGIN_X_OFS);
    assign w_vy = $signed({2'b00, r_qy3}) - VY_W'(ssps_pkg::ORIGIN_Y_OFS);

    // stage 4: ray origin
    logic               r_v4;
    logic signed [15:0] r_ox4, r_oy4;
    logic signed [16:0] w_oxe, w_oye, w_dxg, w_dxb, w_dxm, w_dym;
    assign w_oxe = 17'(r_ox4);
    assign w_oye = 17'(r_oy4);
    assign w_dxg = w_oxe - 17'(ssps_pkg::FIXED_CX);
    assign w_dxb = w_oxe + 17'(ssps_pkg::FIXED_CX);
    assign w_dxm = w_oxe - 17'(i_center_x);
    assign w_dym = w_oye - 17'(i_center_y);

    // stage 5: squares
    logic               r_v5;
    logic signed [15:0] r_ox5, r_oy5;
    logic [SQ_W-1:0]    r_sqg5, r_sqb5, r_sqy5, r_sqmx5, r_sqmy5;
    logic [SUM_W-1:0]   w_sg, w_sb, w_sm;
    ssps_pkg::t_kind    w_kind;
    assign w_sg = SUM_W'(r_sqg5) + SUM_W'(r_sqy5);
    assign w_sb = SUM_W'(r_sqb5) + SUM_W'(r_sqy5);
    assign w_sm = SUM_W'(r_sqmx5) + SUM_W'(r_sqmy5);

    always_comb begin
        priority if (w_sg < SUM_W'(ssps_pkg::RSQ_Q24)) begin
            w_kind = ssps_pkg::KIND_GREEN;
        end else if (w_sb < SUM_W'(ssps_pkg::RSQ_Q24)) begin
            w_kind = ssps_pkg::KIND_BLUE;
        end else if (w_sm <= SUM_W'(ssps_pkg::RSQ_Q24)) begin
            w_kind = ssps_pkg::KIND_MOVE;
        end else begin
            w_kind = ssps_pkg::KIND_SKY;
        end
    end

    // stage 6: classified word
    logic            r_v6;
    ssps_pkg::t_item r_item6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (w_adv) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_col0  <= i_pixel_col;
            r_row0  <= i_pixel_row;
            r_nx1   <= w_nx;
            r_ny1   <= w_ny;
            r_px1   <= PX_W'(w_nx) * PX_W'(REC_X);
            r_py1   <= PY_W'(w_ny) * PY_W'(REC_Y);
            r_nx2   <= r_nx1;
            r_ny2   <= r_ny1;
            r_qex2  <= w_qex;
            r_qey2  <= w_qey;
            r_prx2  <= w_qex * NX_W'(DEN_X);
            r_pry2  <= w_qey * NY_W'(DEN_Y);
            r_qx3   <= r_qex2 + NX_W'((r_nx2 - r_prx2) >= NX_W'(DEN_X));
            r_qy3   <= r_qey2 + NY_W'((r_ny2 - r_pry2) >= NY_W'(DEN_Y));
            r_ox4   <= sat16(32'(w_vx));
            r_oy4   <= sat16(32'(w_vy));
            r_ox5   <= r_ox4;
            r_oy5   <= r_oy4;
            r_sqg5  <= SQ_W'(w_dxg) * SQ_W'(w_dxg);
            r_sqb5  <= SQ_W'(w_dxb) * SQ_W'(w_dxb);
            r_sqy5  <= SQ_W'(w_oye) * SQ_W'(w_oye);
            r_sqmx5 <= SQ_W'(w_dxm) * SQ_W'(w_dxm);
            r_sqmy5 <= SQ_W'(w_dym) * SQ_W'(w_dym);
            r_item6.kind <= w_kind;
            r_item6.ox   <= r_ox5;
            r_item6.oy   <= r_oy5;
            r_item6.harg <= ssps_pkg::HARG_W'(SUM_W'(ssps_pkg::RSQ_Q24) - w_sm);
        end
    end

    assign o_push = r_v6 && w_adv;
    assign o_item = r_item6;

endmodule
`default_nettype wire

@@ rtl/core/ssps_queue.sv @@
`default_nettype none
module ssps_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ssps_pkg::t_item  i_item,
    output logic                  o_valid,
    output ssps_pkg::t_item       o_item,
    output ssps_pkg::t_qstat      o_qstat
);

    localparam int CNT_W = $clog2(ssps_pkg::QUEUE_DEPTH + 1);

    ssps_pkg::t_item                r_mem [ssps_pkg::QUEUE_DEPTH];
    logic [ssps_pkg::QPTR_W-1:0]    r_wptr, r_rptr;
    logic [CNT_W-1:0]               r_cnt;
    logic                           w_pop;

    // the back end drains a word every cycle one is present
    assign w_pop = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_valid       = w_pop;
    assign o_item        = r_mem[r_rptr];
    assign o_qstat.full  = (r_cnt == CNT_W'(ssps_pkg::QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

endmodule
`default_nettype wire

@@ rtl/core/ssps_back.sv @@
`default_nettype none
module ssps_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire ssps_pkg::t_item  i_item,
    output logic                  o_valid,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output ssps_pkg::t_kind       o_kind
);

    localparam int NS     = ssps_pkg::DIV_STEPS;
    localparam int GEO_W  = $bits(ssps_pkg::t_geo);
    localparam int LSB_W  = $bits(ssps_pkg::t_lsb);
    localparam int H_W    = (ssps_pkg::HARG_W + 1) / 2;
    localparam int LEN_IN = 32;
    localparam int LEN_W  = LEN_IN / 2;
    localparam int DREM_W = 28;
    localparam int DSH_W  = DREM_W + 1;
    localparam int V_W    = 14;
    localparam int P_W    = 31;
    localparam int T_W    = 16;

    // input register
    logic            r_b0_v;
    ssps_pkg::t_item r_b0_item;
    ssps_pkg::t_geo  w_b0_geo;
    assign w_b0_geo.kind = r_b0_item.kind;
    assign w_b0_geo.ox   = r_b0_item.ox;
    assign w_b0_geo.oy   = r_b0_item.oy;

    // depth below the surface
    logic             w_h_v;
    logic [H_W-1:0]   w_h;
    logic [GEO_W-1:0] w_h_sb;
    ssps_pkg::t_geo   w_h_geo;
    logic [ssps_pkg::NZ_W-1:0] w_nz;
    logic signed [15:0]        w_hox, w_hoy;

    ssps_isqrt #(
        .IN_W (ssps_pkg::HARG_W),
        .SB_W (GEO_W)
    ) u_isqrt_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b0_v),
        .i_rad   (r_b0_item.harg),
        .i_sb    (w_b0_geo),
        .o_valid (w_h_v),
        .o_root  (w_h),
        .o_sb    (w_h_sb)
    );

    assign w_h_geo = w_h_sb;
    assign w_hox   = w_h_geo.ox;
    assign w_hoy   = w_h_geo.oy;
    assign w_nz    = ssps_pkg::NZ_W'(ssps_pkg::TENTH_Q12) + ssps_pkg::NZ_W'(w_h);

    // squares of the normal
    logic           r_b1_v;
    ssps_pkg::t_lsb r_b1_lsb;
    logic [30:0]    r_b1_sqx, r_b1_sqy;
    logic [23:0]    r_b1_sqz;

    // squared length
    logic              r_b2_v;
    ssps_pkg::t_lsb    r_b2_lsb;
    logic [LEN_IN-1:0] r_b2_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_v <= 1'b0;
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
        end else begin
            r_b0_v <= i_valid;
            r_b1_v <= w_h_v;
            r_b2_v <= r_b1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0_item    <= i_item;
        r_b1_lsb.geo <= w_h_geo;
        r_b1_lsb.nz  <= w_nz;
        r_b1_sqx     <= 31'($signed(32'(w_hox)) * $signed(32'(w_hox)));
        r_b1_sqy     <= 31'($signed(32'(w_hoy)) * $signed(32'(w_hoy)));
        r_b1_sqz     <= 24'(w_nz) * 24'(w_nz);
        r_b2_lsb     <= r_b1_lsb;
        r_b2_sum     <= LEN_IN'(r_b1_sqx) + LEN_IN'(r_b1_sqy) + LEN_IN'(r_b1_sqz);
    end

    // length of the normal
    logic             w_l_v;
    logic [LEN_W-1:0] w_len;
    logic [LSB_W-1:0] w_l_sb;
    ssps_pkg::t_lsb   w_l_lsb;

    ssps_isqrt #(
        .IN_W (LEN_IN),
        .SB_W (LSB_W)
    ) u_isqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b2_v),
        .i_rad   (r_b2_sum),
        .i_sb    (r_b2_lsb),
        .o_valid (w_l_v),
        .o_root  (w_len),
        .o_sb    (w_l_sb)
    );

    assign w_l_lsb = w_l_sb;

    logic [15:0] w_mag [3];
    logic [1:0]  w_neg0;
    assign w_mag[0] = w_l_lsb.geo.ox[15] ? 16'(-w_l_lsb.geo.ox) : 16'(w_l_lsb.geo.ox);
    assign w_mag[1] = w_l_lsb.geo.oy[15] ? 16'(-w_l_lsb.geo.oy) : 16'(w_l_lsb.geo.oy);
    assign w_mag[2] = 16'(w_l_lsb.nz);
    assign w_neg0   = {w_l_lsb.geo.oy[15], w_l_lsb.geo.ox[15]};

    // restoring divide, three lanes, one quotient bit per stage
    logic [DREM_W-1:0] r_dv_rem  [3][NS-1];
    logic [NS-1:0]     r_dv_q    [3][NS];
    logic [LEN_W-1:0]  r_dv_len  [NS];
    ssps_pkg::t_kind   r_dv_kind [NS];
    logic [1:0]        r_dv_neg  [NS];
    logic              r_dv_v    [NS];

    for (genvar gs = 0; gs < NS; gs++) begin : g_div
        localparam int B = NS - 1 - gs;
        logic [DREM_W-1:0] w_rem  [3];
        logic [NS-1:0]     w_q    [3];
        logic              w_take [3];
        logic [LEN_W-1:0]  w_dlen;
        ssps_pkg::t_kind   w_dkind;
        logic [1:0]        w_dneg;
        logic              w_dv;
        logic [DSH_W-1:0]  w_dsh;

        if (gs == 0) begin : g_first
            for (genvar gl = 0; gl < 3; gl++) begin : g_lane
                assign w_rem[gl] = DREM_W'(w_mag[gl]) << (NS - 1);
                assign w_q[gl]   = '0;
            end
            assign w_dlen  = w_len;
            assign w_dkind = w_l_lsb.geo.kind;
            assign w_dneg  = w_neg0;
            assign w_dv    = w_l_v;
        end else begin : g_next
            for (genvar gl = 0; gl < 3; gl++) begin : g_lane
                assign w_rem[gl] = r_dv_rem[gl][gs-1];
                assign w_q[gl]   = r_dv_q[gl][gs-1];
            end
            assign w_dlen  = r_dv_len[gs-1];
            assign w_dkind = r_dv_kind[gs-1];
            assign w_dneg  = r_dv_neg[gs-1];
            assign w_dv    = r_dv_v[gs-1];
        end

        assign w_dsh = DSH_W'(w_dlen) << B;

        for (genvar gl = 0; gl < 3; gl++) begin : g_cmp
            assign w_take[gl] = DSH_W'(w_rem[gl]) >= w_dsh;
            always_ff @(posedge i_clk) begin
                r_dv_q[gl][gs] <= {w_q[gl][NS-2:0], w_take[gl]};
            end
            if (gs < NS - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    r_dv_rem[gl][gs] <= w_take[gl] ? (w_rem[gl] - w_dsh[DREM_W-1:0])
                                                   : w_rem[gl];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[gs] <= 1'b0;
            end else begin
                r_dv_v[gs] <= w_dv;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_len[gs]  <= w_dlen;
            r_dv_kind[gs] <= w_dkind;
            r_dv_neg[gs]  <= w_dneg;
        end
    end

    // byte conversion
    logic            w_lneg [3];
    logic [NS-1:0]   w_qc   [3];
    assign w_lneg[0] = r_dv_neg[NS-1][0];
    assign w_lneg[1] = r_dv_neg[NS-1][1];
    assign w_lneg[2] = 1'b0;

    for (genvar gl = 0; gl < 3; gl++) begin : g_clamp
        assign w_qc[gl] = (r_dv_q[gl][NS-1] > NS'(ssps_pkg::ONE_Q12))
                        ? NS'(ssps_pkg::ONE_Q12) : r_dv_q[gl][NS-1];
    end

    logic            r_t0_v, r_t1_v, r_t2_v;
    ssps_pkg::t_kind r_t0_kind, r_t1_kind, r_t2_kind;
    logic [V_W-1:0]  r_t0_n [3];
    logic [P_W-1:0]  r_t1_p [3];
    logic [T_W-1:0]  r_t2_t [3];
    logic [7:0]      r_t2_qe [3];
    logic [T_W-1:0]  w_t    [3];
    logic [7:0]      w_byte [3];

    for (genvar gl = 0; gl < 3; gl++) begin : g_byte
        logic [T_W-1:0] w_rm;
        assign w_t[gl]    = T_W'(r_t1_p[gl] >> 16);
        assign w_rm       = r_t2_t[gl] - T_W'(r_t2_qe[gl]) * T_W'(ssps_pkg::BYTE_DIV);
        assign w_byte[gl] = r_t2_qe[gl] + 8'(w_rm >= T_W'(ssps_pkg::BYTE_DIV));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_v  <= 1'b0;
            r_t1_v  <= 1'b0;
            r_t2_v  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_t0_v  <= r_dv_v[NS-1];
            r_t1_v  <= r_t0_v;
            r_t2_v  <= r_t1_v;
            o_valid <= r_t2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t0_kind <= r_dv_kind[NS-1];
        r_t1_kind <= r_t0_kind;
        r_t2_kind <= r_t1_kind;
        for (int l = 0; l < 3; l++) begin
            r_t0_n[l]  <= w_lneg[l] ? (V_W'(ssps_pkg::ONE_Q12) - V_W'(w_qc[l]))
                                    : (V_W'(ssps_pkg::ONE_Q12) + V_W'(w_qc[l]));
            r_t1_p[l]  <= P_W'(r_t0_n[l]) * P_W'(ssps_pkg::BYTE_SCALE);
            r_t2_t[l]  <= w_t[l];
            r_t2_qe[l] <= 8'((32'(w_t[l]) * 32'(ssps_pkg::BYTE_REC)) >> 22);
        end
    end

    always_ff @(posedge i_clk) begin
        o_kind <= r_t2_kind;
        unique case (r_t2_kind)
            ssps_pkg::KIND_GREEN: begin
                o_red   <= 8'd0;
                o_green <= ssps_pkg::FULL;
                o_blue  <= 8'd0;
            end
            ssps_pkg::KIND_BLUE: begin
                o_red   <= 8'd0;
                o_green <= 8'd0;
                o_blue  <= ssps_pkg::FULL;
            end
            ssps_pkg::KIND_MOVE: begin
                o_red   <= w_byte[0];
                o_green <= w_byte[1];
                o_blue  <= w_byte[2];
            end
            default: begin
                o_red   <= ssps_pkg::SKY_R;
                o_green <= ssps_pkg::SKY_G;
                o_blue  <= ssps_pkg::SKY_B;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
module testbench;
    import ssps_pkg::*;

    localparam int IMG_W = 1600;
    localparam int IMG_H = 900;
    localparam int LATENCY = 70;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        t_kind      kind;
    } t_color;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [10:0] i_pixel_col;
    logic [9:0]  i_pixel_row;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [1:0]  o_hit_kind;

    longint center_x;
    longint center_y;
    int      cycles;
    int      sphere_hits;

    sphere_scene_pixel_shader_top #(
        .PIX_COLS(IMG_W),
        .PIX_ROWS(IMG_H)
    ) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pixel_col(i_pixel_col), .i_pixel_row(i_pixel_row),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_red(o_red), .o_green(o_green), .o_blue(o_blue),
        .o_hit_kind(o_hit_kind)
    );

    function automatic longint sat_q12(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic void ray_origin(input int col, input int row,
                                       output longint ox, output longint oy);
        longint denx;
        longint denh;
        denx = 9 * (IMG_W - 1);
        denh = IMG_H - 1;
        ox = sat_q12((131072 * longint'(col) + denx / 2) / denx - ORIGIN_X_OFS);
        oy = sat_q12((8192 * longint'(row) + denh / 2) / denh - ORIGIN_Y_OFS);
    endfunction

    function automatic longint int_sqrt(longint v);
        longint root;
        longint bitv;
        root = 0;
        bitv = longint'(1) << 60;
        while (bitv > v) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >>> 1) + bitv;
            end else begin
                root = root >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return root;
    endfunction

    function automatic logic [7:0] normal_byte(longint c, longint len);
        longint mag;
        longint q;
        mag = (c < 0) ? -c : c;
        q = (mag * ONE_Q12) / len;
        if (q > ONE_Q12) q = ONE_Q12;
        if (c < 0) q = -q;
        return 8'((255999 * (q + ONE_Q12)) / 8192000);
    endfunction

    function automatic t_color shade_pixel(int col, int row);
        longint ox, oy, dx, dy, s, nz, len;
        t_color c;
        ray_origin(col, row, ox, oy);
        dx = ox - FIXED_CX;
        dy = ox + FIXED_CX;
        if (dx * dx + oy * oy < RSQ_Q24) begin
            c = '{8'd0, FULL, 8'd0, KIND_GREEN};
        end else if (dy * dy + oy * oy < RSQ_Q24) begin
            c = '{8'd0, 8'd0, FULL, KIND_BLUE};
        end else begin
            dx = ox - center_x;
            dy = oy - center_y;
            s = dx * dx + dy * dy;
            if (s <= RSQ_Q24) begin
                nz = TENTH_Q12 + int_sqrt(RSQ_Q24 - s);
                len = int_sqrt(ox * ox + oy * oy + nz * nz);
                if (len < 1) len = 1;
                c = '{normal_byte(ox, len), normal_byte(oy, len), normal_byte(nz, len),
                      KIND_MOVE};
            end else begin
                c = '{SKY_R, SKY_G, SKY_B, KIND_SKY};
            end
        end
        return c;
    endfunction

    class color_board;
        t_color pending[$];
        int     errors;
        int     checked;

        function void note_pixel(t_color c);
            pending.push_back(c);
        endfunction

        function void check_color(t_color got);
            t_color want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected color word %h", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected r=%0d g=%0d b=%0d k=%0d, got r=%0d g=%0d b=%0d k=%0d",
                             want.red, want.green, want.blue, want.kind,
                             got.red, got.green, got.blue, got.kind);
            end
        endfunction
    endclass

    color_board board;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[sphere_scene_pixel_shader_top] ERROR");
            $finish;
        end
        if (i_rst_n && start && !busy) begin
            board.note_pixel(shade_pixel(i_pixel_col, i_pixel_row));
            if (shade_pixel(i_pixel_col, i_pixel_row).kind == KIND_MOVE) sphere_hits++;
        end
        if (i_rst_n && o_valid)
            board.check_color('{o_red, o_green, o_blue, t_kind'(o_hit_kind)});
    end

    task automatic send_pixel(int col, int row, int gap);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1;
        i_pixel_col <= 11'(col);
        i_pixel_row <= 10'(row);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain;
        start <= 0;
        @(negedge i_clk);
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, longint value);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= 16'(value);
        if (idx == CFG_CENTER_X) center_x = longint'($signed(16'(value)));
        if (idx == CFG_CENTER_Y) center_y = longint'($signed(16'(value)));
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic set_center(longint mx, longint my);
        drain();
        write_reg(CFG_CENTER_X, mx);
        write_reg(CFG_CENTER_Y, my);
    endtask

    task automatic random_phase(int count, bit gaps);
        int col, row, cc, rc, gap;
        cc = int'(((center_x + ORIGIN_X_OFS) * 14391) / 131072);
        rc = int'(((center_y + ORIGIN_Y_OFS) * 899) / 8192);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 2) != 0) begin
                col = cc + $urandom_range(0, 240) - 120;
                row = rc + $urandom_range(0, 130) - 65;
                if (col < 0) col = 0;
                if (col > 2047) col = 2047;
                if (row < 0) row = 0;
                if (row > 1023) row = 1023;
            end else begin
                col = $urandom_range(0, 2047);
                row = $urandom_range(0, 1023);
            end
            gap = gaps ? $urandom_range(0, 10) : 0;
            send_pixel(col, row, gap);
        end
    endtask

    initial begin
        longint tx, ty;
        board = new();
        cycles = 0;
        sphere_hits = 0;
        center_x = 0;
        center_y = 0;
        start = 0;
        i_pixel_col = 0;
        i_pixel_row = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_CENTER_X;
        i_cfg_data = 0;
        i_rst_n = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // corners, out-of-range pixels, fixed sphere centres, reset centre
        send_pixel(0, 0, 0);
        send_pixel(1599, 899, 0);
        send_pixel(2047, 1023, 1);
        send_pixel(0, 1023, 0);
        send_pixel(2047, 0, 3);
        send_pixel(1024, 450, 0);
        send_pixel(575, 450, 0);
        send_pixel(800, 450, 0);
        send_pixel(1365, 0, 2);
        send_pixel(1700, 450, 0);

        // tangent ray and centre hit on the movable sphere
        ray_origin(1500, 800, tx, ty);
        set_center(tx - 2048, ty);
        send_pixel(1500, 800, 0);
        send_pixel(1501, 800, 0);
        set_center(tx, ty);
        send_pixel(1500, 800, 0);
        send_pixel(1500, 801, 2);
        drain();
        write_reg(CFG_SPARE_A, 16'h1234);
        write_reg(CFG_SPARE_B, 16'hffff);
        send_pixel(1500, 800, 0);
        set_center(-32768, 32767);
        send_pixel(0, 1023, 0);
        send_pixel(0, 0, 0);
        set_center(32767, -32768);
        send_pixel(2047, 0, 0);
        send_pixel(2047, 1023, 0);

        for (int p = 0; p < 12; p++) begin
            if (p == 0) set_center(0, 0);
            else if (p == 1) set_center(-32768, -32768);
            else if (p == 2) set_center(32767, 32767);
            else set_center($urandom_range(0, 12000) - 6000,
                            $urandom_range(0, 9000) - 4500);
            random_phase(107, (p % 4) != 3);
        end

        drain();
        if (board.pending.size() != 0) board.errors++;
        $display("covered %0d color words, %0d on the movable sphere, 16 centre settings",
                 board.checked, sphere_hits);
        if (board.errors == 0) begin
            $display("[sphere_scene_pixel_shader_top] OK");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("[sphere_scene_pixel_shader_top] ERROR");
        end
        $finish;
    end
endmodule
